[design/i2c_master_register_transfer_core_macros.svh]
// assertion macros for the i2c register transfer core
`ifndef I2C_MASTER_REGISTER_TRANSFER_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_TRANSFER_CORE_MACROS_SVH

`define IMRT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define IMRT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/imrt_pkg.sv]
`default_nettype none
package imrt_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_QUEUE = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_CHECK, PH_START, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW,
      PH_ACK_HIGH, PH_ACK_HOLD, PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW,
      PH_MACK_HIGH, PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_FREE
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_ACK   = 2'd1,
      ST_BUS_BUSY = 2'd2,
      ST_UNDERRUN = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STAGE_DEVICE   = 2'd0,
      STAGE_REGISTER = 2'd1,
      STAGE_DATA     = 2'd2
   } stage_type;

   localparam logic [0:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [0:0] CSR_ACK_TIMEOUT = 1'b1;
   localparam logic [7:0] MSB_MASK = 8'h80;

   // item handed from the front part to the back part
   typedef struct packed {
      mode_type   mode;
      logic       sda;
      logic       scl;
      logic [7:0] device_byte;
      logic [7:0] register_byte;
      logic       is_read;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
   } cmd_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
      status_type status;
      logic       fifo_full;
   } rsp_type;

endpackage
`default_nettype wire

[design/imrt_stream_if.sv]
`default_nettype none
interface imrt_req_if;
   logic                 valid;
   logic                 ready;
   imrt_pkg::mode_type   mode;
   logic                 sda_in;
   logic                 scl_in;
   logic [7:0]           device_byte;
   logic [7:0]           register_byte;
   logic                 is_read;
   logic [7:0]           byte_count;
   logic [7:0]           write_byte;
   modport source (output valid, mode, sda_in, scl_in, device_byte, register_byte,
                   is_read, byte_count, write_byte, input ready);
   modport sink (input valid, mode, sda_in, scl_in, device_byte, register_byte,
                 is_read, byte_count, write_byte, output ready);
endinterface

interface imrt_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 scl_drive_low;
   logic                 sda_drive_low;
   logic [7:0]           read_byte;
   logic                 read_valid;
   logic                 busy_res;
   logic                 done_res;
   logic [1:0]           status;
   logic                 fifo_full;
   modport source (output valid, scl_drive_low, sda_drive_low, read_byte, read_valid,
                   busy_res, done_res, status, fifo_full, input ready);
   modport sink (input valid, scl_drive_low, sda_drive_low, read_byte, read_valid,
                 busy_res, done_res, status, fifo_full, output ready);
endinterface
`default_nettype wire

[design/imrt_cmd_queue.sv]
`default_nettype none
// front part: takes request items, packs them and queues them for the engine
module imrt_cmd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   imrt_req_if.sink               req,
   output imrt_pkg::cmd_type      cmd_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_take
);
   localparam int DEPTH = 2;

   imrt_pkg::cmd_type slot_ff [DEPTH];
   logic              wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;
   imrt_pkg::cmd_type packed_cmd;

   always_comb begin
      packed_cmd.mode          = req.mode;
      packed_cmd.sda           = req.sda_in;
      packed_cmd.scl           = req.scl_in;
      packed_cmd.device_byte   = req.device_byte;
      packed_cmd.register_byte = req.register_byte;
      packed_cmd.is_read       = req.is_read;
      packed_cmd.byte_count    = req.byte_count;
      packed_cmd.write_byte    = req.write_byte;
   end

   assign req.ready = (count_ff != 2'(DEPTH));
   assign push      = req.valid && req.ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= packed_cmd;
      end
   end
endmodule
`default_nettype wire

[design/imrt_engine.sv]
`default_nettype none
// back part: bus sequencer, write fifo and result register
module imrt_engine #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [0:0]        csr_index,
   input  wire logic [7:0]        csr_write_data,
   input  wire imrt_pkg::cmd_type cmd_data,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   imrt_rsp_if.source             rsp
);
   localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int LW = $clog2(FIFO_DEPTH + 1);

   logic [7:0]          half_ff, timeout_ff;
   imrt_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          tick_ff, tick_in;
   logic [3:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          left_ff, left_in;
   logic                dir_ff, dir_in;
   logic [7:0]          reg_ff, reg_in;
   imrt_pkg::stage_type stage_ff, stage_in;
   logic [LW-1:0]       level_ff, level_in;
   logic [AW-1:0]       head_ff, head_in;
   logic                scl_ff, scl_in_n, sda_ff, sda_in_n;
   imrt_pkg::status_type status_ff, status_in;
   logic [7:0]          mem [FIFO_DEPTH];
   logic [7:0]          rd_data_ff;
   logic [7:0]          fifo_out;
   logic                fifo_push, fifo_pop;
   logic [AW-1:0]       wr_addr;
   logic                got_valid, ended, half_done, step;
   logic [7:0]          got;
   logic [7:0]          half_eff, shifted;
   logic [3:0]          bit_next;
   logic                out_valid_ff;
   imrt_pkg::rsp_type   out_ff, out_in;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [LW-1:0] b);
      logic [LW:0] s;
      s = {{(LW+1-AW){1'b0}}, a} + {1'b0, b};
      if (s >= (LW+1)'(FIFO_DEPTH)) begin
         s = s - (LW+1)'(FIFO_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   // the result register takes a new item whenever it is empty or being drained
   assign step      = cmd_valid && (!out_valid_ff || rsp.ready);
   assign cmd_take  = step;
   assign half_eff  = (half_ff == 8'd0) ? 8'd1 : half_ff;
   assign half_done = ({1'b0, tick_ff} + 9'd1) >= {1'b0, half_eff};
   assign fifo_out  = rd_data_ff;
   assign wr_addr   = wrap_add(head_ff, level_ff);
   assign shifted   = {shift_ff[6:0], 1'b0};
   assign bit_next  = bit_ff + 4'd1;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      dir_in    = dir_ff;
      reg_in    = reg_ff;
      stage_in  = stage_ff;
      head_in   = head_ff;
      scl_in_n  = scl_ff;
      sda_in_n  = sda_ff;
      status_in = status_ff;
      fifo_push = 1'b0;
      fifo_pop  = 1'b0;
      got       = 8'd0;
      got_valid = 1'b0;
      ended     = 1'b0;
      if (step) begin
         case (cmd_data.mode)
            imrt_pkg::MODE_START: begin
               if (phase_ff == imrt_pkg::PH_IDLE) begin
                  shift_in  = cmd_data.device_byte;
                  reg_in    = cmd_data.register_byte;
                  dir_in    = cmd_data.is_read;
                  left_in   = cmd_data.byte_count;
                  stage_in  = imrt_pkg::STAGE_DEVICE;
                  bit_in    = 4'd0;
                  tick_in   = 8'd0;
                  status_in = imrt_pkg::ST_OK;
                  scl_in_n  = 1'b0;
                  sda_in_n  = 1'b0;
                  phase_in  = imrt_pkg::PH_CHECK;
               end
            end
            imrt_pkg::MODE_QUEUE: begin
               fifo_push = (level_ff < LW'(FIFO_DEPTH));
            end
            imrt_pkg::MODE_TICK: begin
               if (phase_ff != imrt_pkg::PH_IDLE && phase_ff != imrt_pkg::PH_CHECK &&
                   phase_ff != imrt_pkg::PH_ACK_HIGH) begin
                  tick_in = half_done ? 8'd0 : tick_ff + 8'd1;
               end
               case (phase_ff)
                  imrt_pkg::PH_CHECK: begin
                     if (cmd_data.sda && cmd_data.scl) begin
                        tick_in  = 8'd0;
                        sda_in_n = 1'b1;
                        phase_in = imrt_pkg::PH_START;
                     end else begin
                        status_in = imrt_pkg::ST_BUS_BUSY;
                        phase_in  = imrt_pkg::PH_IDLE;
                        ended     = 1'b1;
                     end
                  end
                  imrt_pkg::PH_START: begin
                     if (half_done) begin
                        stage_in = imrt_pkg::STAGE_DEVICE;
                        bit_in   = 4'd0;
                        phase_in = imrt_pkg::PH_TX_LOW;
                        scl_in_n = 1'b1;
                        sda_in_n = ~shift_ff[7];
                     end
                  end
                  imrt_pkg::PH_TX_LOW: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        phase_in = imrt_pkg::PH_TX_HIGH;
                     end
                  end
                  imrt_pkg::PH_TX_HIGH: begin
                     if (half_done) begin
                        shift_in = shifted;
                        bit_in   = bit_next;
                        scl_in_n = 1'b1;
                        if (bit_next >= 4'd8) begin
                           sda_in_n = 1'b0;
                           phase_in = imrt_pkg::PH_ACK_LOW;
                        end else begin
                           sda_in_n = (shifted & imrt_pkg::MSB_MASK) == 8'd0;
                           phase_in = imrt_pkg::PH_TX_LOW;
                        end
                     end
                  end
                  imrt_pkg::PH_ACK_LOW: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        sda_in_n = 1'b0;
                        phase_in = imrt_pkg::PH_ACK_HIGH;
                     end
                  end
                  imrt_pkg::PH_ACK_HIGH: begin
                     if (!cmd_data.sda) begin
                        tick_in  = 8'd0;
                        phase_in = imrt_pkg::PH_ACK_HOLD;
                     end else if (tick_ff >= timeout_ff) begin
                        status_in = imrt_pkg::ST_NO_ACK;
                        phase_in  = imrt_pkg::PH_STOP_LOW;
                        tick_in   = 8'd0;
                        scl_in_n  = 1'b1;
                        sda_in_n  = 1'b1;
                     end else begin
                        tick_in = tick_ff + 8'd1;
                     end
                  end
                  imrt_pkg::PH_ACK_HOLD: begin
                     if (half_done) begin
                        scl_in_n = 1'b1;
                        sda_in_n = 1'b0;
                        if (stage_ff == imrt_pkg::STAGE_DEVICE && dir_ff) begin
                           if (left_ff == 8'd0) begin
                              status_in = imrt_pkg::ST_OK;
                              phase_in  = imrt_pkg::PH_STOP_LOW;
                              sda_in_n  = 1'b1;
                           end else begin
                              shift_in = 8'd0;
                              bit_in   = 4'd0;
                              phase_in = imrt_pkg::PH_RX_LOW;
                           end
                        end else if (stage_ff == imrt_pkg::STAGE_DEVICE) begin
                           stage_in = imrt_pkg::STAGE_REGISTER;
                           shift_in = reg_ff;
                           bit_in   = 4'd0;
                           phase_in = imrt_pkg::PH_TX_LOW;
                           sda_in_n = ~reg_ff[7];
                        end else if (left_ff == 8'd0 || level_ff == LW'(0)) begin
                           status_in = (left_ff == 8'd0) ? imrt_pkg::ST_OK
                                                         : imrt_pkg::ST_UNDERRUN;
                           phase_in  = imrt_pkg::PH_STOP_LOW;
                           sda_in_n  = 1'b1;
                        end else begin
                           fifo_pop = 1'b1;
                           head_in  = wrap_add(head_ff, LW'(1));
                           left_in  = left_ff - 8'd1;
                           stage_in = imrt_pkg::STAGE_DATA;
                           shift_in = fifo_out;
                           bit_in   = 4'd0;
                           phase_in = imrt_pkg::PH_TX_LOW;
                           sda_in_n = ~fifo_out[7];
                        end
                     end
                  end
                  imrt_pkg::PH_RX_LOW: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        sda_in_n = 1'b0;
                        phase_in = imrt_pkg::PH_RX_HIGH;
                     end
                  end
                  imrt_pkg::PH_RX_HIGH: begin
                     if (half_done) begin
                        shift_in = {shift_ff[6:0], cmd_data.sda};
                        bit_in   = bit_next;
                        scl_in_n = 1'b1;
                        if (bit_next >= 4'd8) begin
                           got       = {shift_ff[6:0], cmd_data.sda};
                           got_valid = 1'b1;
                           if (left_ff != 8'd0) begin
                              left_in = left_ff - 8'd1;
                           end
                           sda_in_n = (left_ff > 8'd1);
                           phase_in = imrt_pkg::PH_MACK_LOW;
                        end else begin
                           sda_in_n = 1'b0;
                           phase_in = imrt_pkg::PH_RX_LOW;
                        end
                     end
                  end
                  imrt_pkg::PH_MACK_LOW: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        phase_in = imrt_pkg::PH_MACK_HIGH;
                     end
                  end
                  imrt_pkg::PH_MACK_HIGH: begin
                     if (half_done) begin
                        scl_in_n = 1'b1;
                        if (left_ff != 8'd0) begin
                           shift_in = 8'd0;
                           bit_in   = 4'd0;
                           sda_in_n = 1'b0;
                           phase_in = imrt_pkg::PH_RX_LOW;
                        end else begin
                           status_in = imrt_pkg::ST_OK;
                           phase_in  = imrt_pkg::PH_STOP_LOW;
                           sda_in_n  = 1'b1;
                        end
                     end
                  end
                  imrt_pkg::PH_STOP_LOW: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        sda_in_n = 1'b1;
                        phase_in = imrt_pkg::PH_STOP_HIGH;
                     end
                  end
                  imrt_pkg::PH_STOP_HIGH: begin
                     if (half_done) begin
                        scl_in_n = 1'b0;
                        sda_in_n = 1'b0;
                        phase_in = imrt_pkg::PH_STOP_FREE;
                     end
                  end
                  imrt_pkg::PH_STOP_FREE: begin
                     if (half_done) begin
                        phase_in = imrt_pkg::PH_IDLE;
                        ended    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      level_in = level_ff + LW'(fifo_push) - LW'(fifo_pop);
      out_in.scl_drive_low = scl_in_n;
      out_in.sda_drive_low = sda_in_n;
      out_in.read_byte     = got;
      out_in.read_valid    = got_valid;
      out_in.busy_res      = (phase_in != imrt_pkg::PH_IDLE);
      out_in.done_res      = ended;
      out_in.status        = status_in;
      out_in.fifo_full     = (level_in >= LW'(FIFO_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff      <= 8'd2;
         timeout_ff   <= 8'd2;
         phase_ff     <= imrt_pkg::PH_IDLE;
         tick_ff      <= 8'd0;
         bit_ff       <= 4'd0;
         shift_ff     <= 8'd0;
         left_ff      <= 8'd0;
         dir_ff       <= 1'b0;
         reg_ff       <= 8'd0;
         stage_ff     <= imrt_pkg::STAGE_DEVICE;
         level_ff     <= '0;
         head_ff      <= '0;
         scl_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         status_ff    <= imrt_pkg::ST_OK;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == imrt_pkg::CSR_HALF_PERIOD) begin
               half_ff <= csr_write_data;
            end else begin
               timeout_ff <= csr_write_data;
            end
         end
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         left_ff   <= left_in;
         dir_ff    <= dir_in;
         reg_ff    <= reg_in;
         stage_ff  <= stage_in;
         level_ff  <= level_in;
         head_ff   <= head_in;
         scl_ff    <= scl_in_n;
         sda_ff    <= sda_in_n;
         status_ff <= status_in;
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= out_in;
      end
      if (fifo_push) begin
         mem[wr_addr] <= cmd_data.write_byte;
      end
      // registered read of the next head, with the byte being written passed through
      if (fifo_push && wr_addr == head_in) begin
         rd_data_ff <= cmd_data.write_byte;
      end else begin
         rd_data_ff <= mem[head_in];
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.scl_drive_low = out_ff.scl_drive_low;
   assign rsp.sda_drive_low = out_ff.sda_drive_low;
   assign rsp.read_byte     = out_ff.read_byte;
   assign rsp.read_valid    = out_ff.read_valid;
   assign rsp.busy_res      = out_ff.busy_res;
   assign rsp.done_res      = out_ff.done_res;
   assign rsp.status        = out_ff.status;
   assign rsp.fifo_full     = out_ff.fifo_full;
endmodule
`default_nettype wire

[design/i2c_master_register_transfer_core.sv]
// I2C register transfer master. Every request item (pin-sample tick, start,
// write-fifo push or no-op) yields exactly one response item carrying the
// line drives and status after that item. One item is taken per clock while
// responses drain: a two-entry command queue feeds the sequencer, whose update and
// response register set the rate; queue and response register decouple the two
// handshakes. The write fifo is FIFO_DEPTH bytes of plain memory, no clearing pass.
`default_nettype none
module i2c_master_register_transfer_core #(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [0:0] csr_index,
   input  wire logic [7:0] csr_write_data,
   imrt_req_if.sink        req,
   imrt_rsp_if.source      rsp
);
   imrt_pkg::cmd_type cmd_data;
   logic              cmd_valid, cmd_take;

   imrt_cmd_queue u_front (
      .clock(clock), .reset(reset), .req(req),
      .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
   );

   imrt_engine #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .cmd_data(cmd_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
      .rsp(rsp)
   );
endmodule
`default_nettype wire

[design/imrt_checker.sv]
`default_nettype none
`include "i2c_master_register_transfer_core_macros.svh"
module imrt_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_busy,
   input wire logic rsp_done,
   input wire logic rsp_read_valid,
   input wire logic [1:0] rsp_status
);
   // a finished transaction is no longer busy
   `IMRT_ASSERT_IMPL(a_done_idle, clock, reset, rsp_valid && rsp_done, !rsp_busy, "done while busy")
   // bytes only arrive mid transfer
   `IMRT_ASSERT_IMPL(a_read_busy, clock, reset, rsp_valid && rsp_read_valid, rsp_busy && !rsp_done, "read outside transfer")
   // bus busy status is never reported while a transfer is active
   `IMRT_ASSERT_IMPL(a_busy_stat, clock, reset, rsp_valid && rsp_status == imrt_pkg::ST_BUS_BUSY && rsp_busy, 1'b0, "bus busy while active")
   `IMRT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "stalled item changed")
endmodule

bind i2c_master_register_transfer_core imrt_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_busy(rsp.busy_res), .rsp_done(rsp.done_res), .rsp_read_valid(rsp.read_valid),
   .rsp_status(rsp.status)
);
`default_nettype wire
